// File: rtl/assert_macros.svh
// Assertion helpers, clocked on clk with rst_n as the disable
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every edge out of reset
`define ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed: invariant");

// consequent holds at the same edge as the antecedent
`define ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: implication");

// consequent holds at the edge after the antecedent
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// File: rtl/rpf_pkg.sv
package rpf_pkg;

    // field widths
    localparam int DIST_W  = 16;
    localparam int SPEED_W = 16;
    localparam int LIMIT_W = 15;
    localparam int MAG_W   = 32;
    localparam int TIME_W  = 32;
    localparam int MODE_W  = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_NEAR_LIMIT     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NEAR_SPEED_MIN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_NEAR_MAG_MIN   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FAR_SPEED_MIN  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FAR_MAG_MIN    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LEAVE_TIMEOUT  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_RADAR_ON       = 3'd6;

    // register reset values
    localparam logic [DIST_W-1:0] NEAR_LIMIT_RST    = 16'd100;
    localparam logic [TIME_W-1:0] LEAVE_TIMEOUT_RST = 32'd1000;

    typedef enum logic [MODE_W-1:0] {
        MODE_IDLE         = 2'd0,
        MODE_CLOSE        = 2'd1,
        MODE_LEAVE_ARM    = 2'd2,
        MODE_LEAVE_REPORT = 2'd3
    } rpf_mode_t;

    typedef struct packed {
        logic [DIST_W-1:0]  near_limit_cm;
        logic [LIMIT_W-1:0] near_speed_min;
        logic [MAG_W-1:0]   near_mag_min;
        logic [LIMIT_W-1:0] far_speed_min;
        logic [MAG_W-1:0]   far_mag_min;
        logic [TIME_W-1:0]  leave_timeout_ms;
        logic               radar_on;
    } rpf_cfg_t;

    typedef struct packed {
        logic [DIST_W-1:0]         distance_cm;
        logic signed [SPEED_W-1:0] speed_q8;
        logic [MAG_W-1:0]          magnitude;
        logic [TIME_W-1:0]         time_ms;
    } rpf_item_t;

    typedef struct packed {
        rpf_mode_t mode;
        logic      near_indicator;
        logic      far_indicator;
        logic      radar_timer_enable;
        logic      leave_pending;
    } rpf_result_t;

endpackage

// File: rtl/rpf_report_if.sv
interface rpf_report_if;
    import rpf_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [DIST_W-1:0]         distance_cm;
    logic signed [SPEED_W-1:0] speed_q8;
    logic [MAG_W-1:0]          magnitude;
    logic [TIME_W-1:0]         time_ms;

    modport source (output valid, distance_cm, speed_q8, magnitude, time_ms, input ready);
    modport sink (input valid, distance_cm, speed_q8, magnitude, time_ms, output ready);
endinterface

// File: rtl/rpf_result_if.sv
interface rpf_result_if;
    import rpf_pkg::*;

    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] mode;
    logic              near_indicator;
    logic              far_indicator;
    logic              radar_timer_enable;
    logic              leave_pending;

    modport source (output valid, mode, near_indicator, far_indicator, radar_timer_enable,
                    leave_pending, input ready);
    modport sink (input valid, mode, near_indicator, far_indicator, radar_timer_enable,
                  leave_pending, output ready);
endinterface

// File: rtl/rpf_cfg_regs.sv
module rpf_cfg_regs (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             wr_en,
    input  logic [rpf_pkg::CFG_IDX_W-1:0]    wr_index,
    input  logic [rpf_pkg::CFG_DATA_W-1:0]   wr_data,
    output rpf_pkg::rpf_cfg_t                cfg
);
    import rpf_pkg::*;

    rpf_cfg_t cfg_reg;
    rpf_cfg_t cfg_next;

    // decode the write; unknown indexes leave everything as it was
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (wr_index)
                REG_NEAR_LIMIT:     cfg_next.near_limit_cm    = wr_data[DIST_W-1:0];
                REG_NEAR_SPEED_MIN: cfg_next.near_speed_min   = wr_data[LIMIT_W-1:0];
                REG_NEAR_MAG_MIN:   cfg_next.near_mag_min     = wr_data[MAG_W-1:0];
                REG_FAR_SPEED_MIN:  cfg_next.far_speed_min    = wr_data[LIMIT_W-1:0];
                REG_FAR_MAG_MIN:    cfg_next.far_mag_min      = wr_data[MAG_W-1:0];
                REG_LEAVE_TIMEOUT:  cfg_next.leave_timeout_ms = wr_data[TIME_W-1:0];
                REG_RADAR_ON:       cfg_next.radar_on         = wr_data[0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.near_limit_cm    <= NEAR_LIMIT_RST;
            cfg_reg.near_speed_min   <= '0;
            cfg_reg.near_mag_min     <= '0;
            cfg_reg.far_speed_min    <= '0;
            cfg_reg.far_mag_min      <= '0;
            cfg_reg.leave_timeout_ms <= LEAVE_TIMEOUT_RST;
            cfg_reg.radar_on         <= 1'b1;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: rtl/rpf_fsm.sv
module rpf_fsm (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  step,
    input  rpf_pkg::rpf_item_t    item,
    input  rpf_pkg::rpf_cfg_t     cfg,
    output rpf_pkg::rpf_result_t  res
);
    import rpf_pkg::*;
    `include "assert_macros.svh"

    rpf_mode_t         mode_reg, mode_next;
    logic              armed_reg, armed_next;
    logic [TIME_W-1:0] start_reg, start_next;
    logic              near_reg, near_next;
    logic              far_reg, far_next;
    logic              ten_reg, ten_next;

    logic [SPEED_W:0]  speed_ext;
    logic [SPEED_W:0]  speed_abs;
    logic [TIME_W-1:0] age;
    logic              is_near, near_hit, far_hit, timed_out;

    // report classification for the idle step
    always_comb
    begin
        speed_ext = {item.speed_q8[SPEED_W-1], item.speed_q8};
        speed_abs = item.speed_q8[SPEED_W-1] ? (-speed_ext) : speed_ext;
        age       = item.time_ms - start_reg;  // wraps with the tick
        is_near   = item.distance_cm <= cfg.near_limit_cm;
        near_hit  = is_near && (speed_abs > {2'b00, cfg.near_speed_min})
                    && (item.magnitude > cfg.near_mag_min);
        far_hit   = !is_near && (speed_abs > {2'b00, cfg.far_speed_min})
                    && (item.magnitude > cfg.far_mag_min);
        timed_out = armed_reg && (age > cfg.leave_timeout_ms);
    end

    // next mode
    always_comb
    begin
        case (mode_reg)
            MODE_IDLE:
            begin
                if (timed_out)
                    mode_next = MODE_LEAVE_REPORT;
                else if (near_hit)
                    mode_next = MODE_CLOSE;
                else if (far_hit)
                    mode_next = MODE_LEAVE_ARM;
                else
                    mode_next = MODE_IDLE;
            end
            default: mode_next = MODE_IDLE;
        endcase
    end

    // levels and leave timer
    always_comb
    begin
        armed_next = armed_reg;
        start_next = start_reg;
        near_next  = near_reg;
        far_next   = far_reg;
        ten_next   = ten_reg;
        case (mode_reg)
            MODE_IDLE:
            begin
                if (timed_out)
                    armed_next = 1'b0;
            end
            MODE_CLOSE:
            begin
                near_next  = 1'b1;
                far_next   = 1'b0;
                ten_next   = cfg.radar_on;
                armed_next = 1'b0;
            end
            MODE_LEAVE_ARM:
            begin
                start_next = item.time_ms;
                armed_next = 1'b1;
            end
            MODE_LEAVE_REPORT:
            begin
                near_next = 1'b0;
                far_next  = 1'b1;
                ten_next  = 1'b0;
            end
            default: armed_next = armed_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_IDLE;
            armed_reg <= 1'b0;
            start_reg <= '0;
            near_reg  <= 1'b0;
            far_reg   <= 1'b0;
            ten_reg   <= 1'b0;
        end
        else if (step)
        begin
            mode_reg  <= mode_next;
            armed_reg <= armed_next;
            start_reg <= start_next;
            near_reg  <= near_next;
            far_reg   <= far_next;
            ten_reg   <= ten_next;
        end
    end

    // result of the step being taken this cycle
    assign res.mode               = mode_next;
    assign res.near_indicator     = near_next;
    assign res.far_indicator      = far_next;
    assign res.radar_timer_enable = ten_next;
    assign res.leave_pending      = armed_next;

    `ASSERT_NEXT(a_nonidle_returns, step && (mode_reg != MODE_IDLE), mode_reg == MODE_IDLE)
    `ASSERT_IMPL(a_report_needs_arm, step && (mode_next == MODE_LEAVE_REPORT), armed_reg)
    `ASSERT_ALWAYS(a_levels_exclusive, !(near_reg && far_reg))
    `ASSERT_IMPL(a_timer_off_when_far, far_reg, !ten_reg)

endmodule

// File: rtl/radar_presence_fsm_core.sv
// Radar presence detector.
// Channels: report (sink) carries one radar report per transfer: distance,
// signed Q8.8 speed, echo magnitude and millisecond tick. result (source)
// carries one result per report: mode, near and far indicators, radar timer
// enable and leave pending. Both use valid/ready; a transfer happens on a
// clock edge with both high. Thresholds are set through the wr_en/wr_index/
// wr_data port, one register per cycle; the user must write them only while
// no report is in flight, and the block itself does not enforce it.
// Throughput: one report per cycle while result is not held off; the next
// mode and timer check are combinational between input and result registers.
// Stall: while result is held off, one further report is still taken into
// the input register; after that report.ready drops until the result moves.
// Reset (rst_n, asynchronous): both stages empty, mode idle, timer disarmed,
// all levels low, registers at their defaults.
module radar_presence_fsm_core (
    input  logic                            clk,
    input  logic                            rst_n,
    rpf_report_if.sink                      report,
    rpf_result_if.source                    result,
    input  logic                            wr_en,
    input  logic [rpf_pkg::CFG_IDX_W-1:0]   wr_index,
    input  logic [rpf_pkg::CFG_DATA_W-1:0]  wr_data
);
    import rpf_pkg::*;
    `include "assert_macros.svh"

    rpf_cfg_t    cfg;
    rpf_item_t   item_reg;
    logic        in_valid_reg;
    rpf_result_t res_next;
    rpf_result_t res_reg;
    logic        out_valid_reg;
    logic        advance;
    logic        step;

    rpf_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .cfg      (cfg)
    );

    // pipeline control
    assign advance      = !out_valid_reg || result.ready;
    assign step         = in_valid_reg && advance;
    assign report.ready = !in_valid_reg || advance;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (report.ready)
            in_valid_reg <= report.valid;
    end

    always_ff @(posedge clk)
    begin
        if (report.valid && report.ready)
        begin
            item_reg.distance_cm <= report.distance_cm;
            item_reg.speed_q8    <= report.speed_q8;
            item_reg.magnitude   <= report.magnitude;
            item_reg.time_ms     <= report.time_ms;
        end
    end

    rpf_fsm u_fsm (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .item  (item_reg),
        .cfg   (cfg),
        .res   (res_next)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= in_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (step)
            res_reg <= res_next;
    end

    assign result.valid              = out_valid_reg;
    assign result.mode               = res_reg.mode;
    assign result.near_indicator     = res_reg.near_indicator;
    assign result.far_indicator      = res_reg.far_indicator;
    assign result.radar_timer_enable = res_reg.radar_timer_enable;
    assign result.leave_pending      = res_reg.leave_pending;

    `ASSERT_IMPL(a_full_blocks_input, in_valid_reg && out_valid_reg && !result.ready, !report.ready)
    `ASSERT_NEXT(a_step_fills_output, step, out_valid_reg)
    `ASSERT_NEXT(a_stall_keeps_item, in_valid_reg && !advance, in_valid_reg && $stable(item_reg))

endmodule
